@@ rtl/baseline_signal_word_packer_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the baseline/signal word packer
// Shared helpers for concurrent checks clocked on clk.
// ---------------------------------------------------------------------------
`ifndef BASELINE_SIGNAL_WORD_PACKER_TOP_DEFINES_SVH
`define BASELINE_SIGNAL_WORD_PACKER_TOP_DEFINES_SVH

// Check a property on every edge outside reset
`define BSWP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every edge, reset included
`define BSWP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/bswp_pkg.sv @@
// ---------------------------------------------------------------------------
// Baseline/signal word packer package
// Field widths, packing geometry, register indexes and tag reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bswp_pkg;

    // Field widths
    localparam int SampleWidth   = 13;
    localparam int WordWidth     = 32;
    localparam int CfgIndexWidth = 3;

    // Packing geometry
    localparam int BlPerWord     = 5;
    localparam int BlSpacing     = 6;
    localparam int SigSpacing    = 13;
    localparam int CountShift    = 24;
    localparam int BlCountWidth  = 3;
    localparam int ShiftWidth    = 5;

    localparam logic [BlCountWidth-1:0] BL_LAST_SLOT = BlCountWidth'(BlPerWord - 1);

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_BASELINE_FULL    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_BASELINE_PARTIAL = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SIGNAL_FULL      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SIGNAL_PARTIAL   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SYNC             = 3'd4;

    // Tag reset values
    localparam logic [WordWidth-1:0] BASELINE_FULL_RST    = 32'h4000_0000;
    localparam logic [WordWidth-1:0] BASELINE_PARTIAL_RST = 32'hE000_0000;
    localparam logic [WordWidth-1:0] SIGNAL_FULL_RST      = 32'h2800_0000;
    localparam logic [WordWidth-1:0] SIGNAL_PARTIAL_RST   = 32'h2C00_0000;
    localparam logic [WordWidth-1:0] SYNC_RST             = 32'h0000_0000;

endpackage

@@ rtl/baseline_signal_word_packer_top.sv @@
// One sample enters per beat and leaves as one result beat (word, word_ready) through
// an input register, then a single pass of shift/OR packing logic into the result
// register that holds the last completed word. Both registers advance together
// whenever the result register is empty or being taken, so the block sustains one
// sample per clock; only out_ready sets the pace. Tag registers must be written while
// no sample is in flight.
// ---------------------------------------------------------------------------
// Baseline/signal word packer, top level
// Packs five 6-bit-spaced baseline samples or two 13-bit-spaced signal samples
// into tagged 32-bit words, flushing any partial word on a mode change.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module baseline_signal_word_packer_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bswp_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [bswp_pkg::WordWidth-1:0]        cfg_data,
    // sample channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [bswp_pkg::SampleWidth-1:0]      sample,
    input  logic                                  is_baseline,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bswp_pkg::WordWidth-1:0]        word,
    output logic                                  word_ready
);

    // Tag registers
    logic [bswp_pkg::WordWidth-1:0] bl_full_tag_reg;
    logic [bswp_pkg::WordWidth-1:0] bl_part_tag_reg;
    logic [bswp_pkg::WordWidth-1:0] sig_full_tag_reg;
    logic [bswp_pkg::WordWidth-1:0] sig_part_tag_reg;
    logic [bswp_pkg::WordWidth-1:0] sync_tag_reg;

    // Input stage
    logic                               s1_valid_reg;
    logic [bswp_pkg::SampleWidth-1:0]   s1_sample_reg;
    logic                               s1_base_reg;

    // Packing state
    logic                               sig_mode_reg, sig_mode_next;
    logic [bswp_pkg::BlCountWidth-1:0]  bl_count_reg, bl_count_next;
    logic                               sig_count_reg, sig_count_next;
    logic [bswp_pkg::WordWidth-1:0]     pack_reg, pack_next;

    // Result stage
    logic                               out_valid_reg;
    logic [bswp_pkg::WordWidth-1:0]     last_word_reg, last_word_next;
    logic                               word_ready_reg, word_ready_next;

    logic                               advance;
    logic [bswp_pkg::WordWidth-1:0]     sample_ext;
    logic [bswp_pkg::ShiftWidth-1:0]    bl_shift;
    logic [bswp_pkg::ShiftWidth-1:0]    sig_shift;
    logic [bswp_pkg::WordWidth-1:0]     bl_sum;
    logic [bswp_pkg::WordWidth-1:0]     sig_sum;
    logic [bswp_pkg::WordWidth-1:0]     bl_count_field;

    // Handshake
    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign word      = last_word_reg;
    assign word_ready = word_ready_reg;

    // Write tag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_full_tag_reg  <= bswp_pkg::BASELINE_FULL_RST;
            bl_part_tag_reg  <= bswp_pkg::BASELINE_PARTIAL_RST;
            sig_full_tag_reg <= bswp_pkg::SIGNAL_FULL_RST;
            sig_part_tag_reg <= bswp_pkg::SIGNAL_PARTIAL_RST;
            sync_tag_reg     <= bswp_pkg::SYNC_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bswp_pkg::REG_BASELINE_FULL:    bl_full_tag_reg  <= cfg_data;
                bswp_pkg::REG_BASELINE_PARTIAL: bl_part_tag_reg  <= cfg_data;
                bswp_pkg::REG_SIGNAL_FULL:      sig_full_tag_reg <= cfg_data;
                bswp_pkg::REG_SIGNAL_PARTIAL:   sig_part_tag_reg <= cfg_data;
                bswp_pkg::REG_SYNC:             sync_tag_reg     <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Capture the incoming beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_sample_reg <= sample;
            s1_base_reg   <= is_baseline;
        end
    end

    // Slot offsets and merged packs
    assign sample_ext     = bswp_pkg::WordWidth'(s1_sample_reg);
    assign bl_shift       = bswp_pkg::ShiftWidth'(bl_count_reg * bswp_pkg::BlSpacing);
    assign sig_shift      = sig_count_reg ? bswp_pkg::ShiftWidth'(bswp_pkg::SigSpacing)
                                          : '0;
    assign bl_sum         = pack_reg | (sample_ext << bl_shift);
    assign sig_sum        = pack_reg | (sample_ext << sig_shift);
    assign bl_count_field = bswp_pkg::WordWidth'(bl_count_reg) << bswp_pkg::CountShift;

    // Pack the held sample, flush on mode change
    always_comb
    begin
        sig_mode_next   = sig_mode_reg;
        bl_count_next   = bl_count_reg;
        sig_count_next  = sig_count_reg;
        pack_next       = pack_reg;
        last_word_next  = last_word_reg;
        word_ready_next = 1'b0;
        if (!sig_mode_reg)
        begin
            if (s1_base_reg)
            begin
                sig_count_next = 1'b0;
                if (bl_count_reg == bswp_pkg::BL_LAST_SLOT)
                begin
                    last_word_next  = bl_full_tag_reg | bl_sum;
                    word_ready_next = 1'b1;
                    bl_count_next   = '0;
                    pack_next       = '0;
                end
                else
                begin
                    bl_count_next = bl_count_reg + 1'b1;
                    pack_next     = bl_sum;
                end
            end
            else
            begin
                if (bl_count_reg != '0)
                begin
                    last_word_next  = bl_part_tag_reg | bl_count_field | pack_reg;
                    word_ready_next = 1'b1;
                end
                sig_count_next = 1'b1;
                bl_count_next  = '0;
                pack_next      = sample_ext;
                sig_mode_next  = 1'b1;
            end
        end
        else
        begin
            if (!s1_base_reg)
            begin
                bl_count_next = '0;
                if (sig_count_reg)
                begin
                    last_word_next  = sig_full_tag_reg | sig_sum;
                    word_ready_next = 1'b1;
                    sig_count_next  = 1'b0;
                    pack_next       = '0;
                end
                else
                begin
                    sig_count_next = 1'b1;
                    pack_next      = sig_sum;
                end
            end
            else
            begin
                if (sig_count_reg)
                begin
                    last_word_next  = sig_part_tag_reg | sync_tag_reg | pack_reg;
                    word_ready_next = 1'b1;
                end
                sig_count_next = 1'b0;
                pack_next      = sample_ext;
                bl_count_next  = bswp_pkg::BlCountWidth'(1);
                sig_mode_next  = 1'b0;
            end
        end
    end

    // Advance packing state and the result register together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_mode_reg   <= 1'b0;
            bl_count_reg   <= '0;
            sig_count_reg  <= 1'b0;
            pack_reg       <= '0;
            last_word_reg  <= '0;
            word_ready_reg <= 1'b0;
        end
        else if (advance)
        begin
            sig_mode_reg   <= sig_mode_next;
            bl_count_reg   <= bl_count_next;
            sig_count_reg  <= sig_count_next;
            pack_reg       <= pack_next;
            last_word_reg  <= last_word_next;
            word_ready_reg <= word_ready_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/bswp_checker.sv @@
// ---------------------------------------------------------------------------
// Baseline/signal word packer port checker
// Watches the top-level ports for beat accounting and word hold behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "baseline_signal_word_packer_top_defines.svh"

module bswp_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [bswp_pkg::WordWidth-1:0]     word,
    input  logic                               word_ready
);

    logic [1:0]                        pending_reg;
    logic [bswp_pkg::WordWidth-1:0]    seen_word_reg;
    logic                              in_beat;
    logic                              out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Count beats in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // Track the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_word_reg <= '0;
        end
        else if (out_beat)
        begin
            seen_word_reg <= word;
        end
    end

    `BSWP_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
    `BSWP_ASSERT(a_out_stall_holds, out_valid && !out_ready |=> out_valid && $stable(word) && $stable(word_ready), "stalled result changed")
    `BSWP_ASSERT(a_no_invented_beat, out_valid |-> pending_reg != 2'd0, "result with no sample in flight")
    `BSWP_ASSERT(a_in_flight_bound, pending_reg != 2'd3, "more than two samples in flight")
    `BSWP_ASSERT(a_word_held, out_beat && !word_ready |-> word == seen_word_reg, "word changed without completion")

endmodule

bind baseline_signal_word_packer_top bswp_checker u_bswp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word       (word),
    .word_ready (word_ready)
);
